[design/fpc_pkg.sv]
// Package with shared types and constants of the frame pacing clock.
`timescale 1ns / 1ps
package fpc_pkg;
  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 32;
  localparam int PERIOD_BITS    = 24;
  localparam int FACTOR_BITS    = 16;
  localparam int MODE_BITS      = 3;
  localparam int EPOCH_BITS     = 64;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 24'd1000000;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd256;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NORMAL    = 3'd0,
    MODE_NRT       = 3'd1,
    MODE_LIMITED   = 3'd2,
    MODE_INTEGER   = 3'd3,
    MODE_INT_LIM   = 3'd4,
    MODE_FORCED    = 3'd5,
    MODE_DEGRADE   = 3'd6,
    MODE_SLAVE     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_FACTOR = 2'd2
  } reg_idx_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV1, ST_DIV2, ST_DIV2W, ST_MUL, ST_MULW,
    ST_FIN, ST_ECFG, ST_ECFGW, ST_OUT
  } state_t;

  // Request to the shared bit-serial arithmetic unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;
endpackage

[design/fpc_serial_unit.sv]
// Bit-serial unit: restoring divider and shift-add multiplier, one bit a cycle.
`timescale 1ns / 1ps
module fpc_serial_unit #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpc_pkg::arith_req_t req,
  input  logic [W-1:0]        op_a,
  input  logic [W-1:0]        op_b,
  output logic                busy,
  output logic [W-1:0]        res_q,
  output logic [W-1:0]        res_r,
  output logic                ovf
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt, busy_r, busy_nxt, ovf_r, ovf_nxt;
  logic [W:0]    trial;
  logic [W:0]    msum;

  assign busy  = busy_r;
  assign res_q = a_r;
  assign res_r = acc_r;
  assign ovf   = ovf_r;

  // One divide or multiply step per cycle.
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    busy_nxt = busy_r;
    ovf_nxt  = ovf_r;
    trial    = {acc_r, a_r[W-1]} - {1'b0, b_r};
    msum     = {1'b0, acc_r} + {1'b0, b_r};
    if (req.start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
      cnt_nxt  = CW'(W);
      div_nxt  = req.is_div;
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[W]) begin
          acc_nxt = trial[W-1:0];
          a_nxt   = {a_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[W-2:0], a_r[W-1]};
          a_nxt   = {a_r[W-2:0], 1'b0};
        end
      end else begin
        // Multiplier bits scanned from the top; overflow flags any carry out.
        if (acc_r[W-1]) ovf_nxt = 1'b1;
        acc_nxt = {acc_r[W-2:0], 1'b0};
        if (a_r[W-1]) begin
          msum = {acc_r, 1'b0} + {1'b0, b_r};
          if (msum[W]) ovf_nxt = 1'b1;
          acc_nxt = msum[W-1:0];
        end
        a_nxt = {a_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    div_r <= div_nxt;
    ovf_r <= ovf_nxt;
  end
endmodule

[design/frame_pacing_clock_top.sv]
// Top level of the frame pacing clock: config port, sequencer and state.
// Path from accept to out_tvalid: normal, limited, slave and integer without arithmetic go
// straight to the result; non-real-time, forced and degrade use one 64-step multiply; integer
// modes use a 64-step divide, then a second divide or a multiply.
// Throughput: one tick at a time; the next request is taken the cycle after the result leaves.
// A mode or period write in an epoch mode blocks requests until the epoch multiply ends; reset
// (synchronous, active low) clears the frame time, delta, epoch and count and loads register defaults.
`timescale 1ns / 1ps
module frame_pacing_clock_top #(
  parameter int TIME_BITS  = fpc_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = fpc_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_time
  input  logic [(TIME_BITS+7)/8*8-1:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // frame_delta, frame_time, frame_number, resume time; lowest bits first
  output logic [(3*TIME_BITS+COUNT_BITS+7)/8*8-1:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int W = fpc_pkg::EPOCH_BITS;
  localparam int OUT_W = (3*TIME_BITS+COUNT_BITS+7)/8*8;
  localparam logic [W-1:0] TMAX = W'({TIME_BITS{1'b1}});

  fpc_pkg::state_t st_r, st_nxt;
  fpc_pkg::mode_t  mode_r;
  logic [fpc_pkg::PERIOD_BITS-1:0] period_r;
  logic [fpc_pkg::FACTOR_BITS-1:0] factor_r;
  logic [TIME_BITS-1:0]  actual_r, reported_r, delta_r, now_r, old_r, wait_r;
  logic [W-1:0]          epoch_r, tmp_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  ecfg_r;
  fpc_pkg::arith_req_t   req;
  logic [W-1:0]          op_a, op_b, res_q, res_r;
  logic                  busy, ovf;
  logic                  wr;
  logic [1:0]            widx;
  logic [W-1:0]          now_w, old_w, dt_w, per_w, cnt_w, act_w, rep_w;
  logic [W-1:0]          target, ep_sum, sat_t;
  logic [W:0]            s1;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx = cfg_paddr[3:2];

  // Register read-back.
  always_comb begin
    case (widx)
      fpc_pkg::REG_MODE:   cfg_prdata = {29'd0, mode_r};
      fpc_pkg::REG_PERIOD: cfg_prdata = {8'd0, period_r};
      fpc_pkg::REG_FACTOR: cfg_prdata = {16'd0, factor_r};
      default:             cfg_prdata = '0;
    endcase
  end

  assign now_w = W'(now_r);
  assign old_w = W'(old_r);
  assign dt_w  = now_w - old_w;
  assign per_w = W'(period_r);
  assign cnt_w = W'(count_r);
  assign act_w = W'(actual_r);
  assign rep_w = W'(reported_r);

  fpc_serial_unit #(.W(W)) u_ser (
    .clk, .rst_n, .req, .op_a, .op_b, .busy, .res_q, .res_r, .ovf
  );

  assign in_tready  = (st_r == fpc_pkg::ST_IDLE) && !wr;
  assign out_tvalid = (st_r == fpc_pkg::ST_OUT);
  assign out_tdata  = OUT_W'({wait_r, count_r, reported_r, delta_r});

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      fpc_pkg::ST_IDLE: begin
        if (wr && (widx == fpc_pkg::REG_MODE || widx == fpc_pkg::REG_PERIOD))
          st_nxt = fpc_pkg::ST_ECFG;
        else if (in_tvalid && in_tready) st_nxt = fpc_pkg::ST_PREP;
      end
      fpc_pkg::ST_PREP: begin
        case (mode_r)
          fpc_pkg::MODE_NRT, fpc_pkg::MODE_FORCED: st_nxt = fpc_pkg::ST_MUL;
          fpc_pkg::MODE_DEGRADE:                   st_nxt = fpc_pkg::ST_MUL;
          fpc_pkg::MODE_INTEGER, fpc_pkg::MODE_INT_LIM: begin
            if (per_w == '0 || (dt_w < per_w && (mode_r == fpc_pkg::MODE_INT_LIM
                || dt_w == '0))) st_nxt = fpc_pkg::ST_FIN;
            else st_nxt = fpc_pkg::ST_DIV1;
          end
          default: st_nxt = fpc_pkg::ST_FIN;
        endcase
      end
      fpc_pkg::ST_DIV1:  st_nxt = fpc_pkg::ST_DIV2;
      fpc_pkg::ST_DIV2:  if (!busy) st_nxt = (dt_w < per_w) ? fpc_pkg::ST_DIV2W
                                                             : fpc_pkg::ST_MUL;
      fpc_pkg::ST_DIV2W: if (!busy) st_nxt = fpc_pkg::ST_FIN;
      fpc_pkg::ST_MUL:   st_nxt = fpc_pkg::ST_MULW;
      fpc_pkg::ST_MULW:  if (!busy) st_nxt = fpc_pkg::ST_FIN;
      fpc_pkg::ST_FIN:   st_nxt = fpc_pkg::ST_OUT;
      fpc_pkg::ST_ECFG:  st_nxt = ecfg_r ? fpc_pkg::ST_ECFGW : fpc_pkg::ST_IDLE;
      fpc_pkg::ST_ECFGW: if (!busy) st_nxt = fpc_pkg::ST_IDLE;
      fpc_pkg::ST_OUT:   if (out_tready) st_nxt = fpc_pkg::ST_IDLE;
      default:           st_nxt = fpc_pkg::ST_IDLE;
    endcase
  end

  // Requests to the serial unit.
  always_comb begin
    req  = '0;
    op_a = '0;
    op_b = '0;
    case (st_r)
      fpc_pkg::ST_DIV1: begin
        req = '{start: 1'b1, is_div: 1'b1};
        op_a = (dt_w < per_w) ? per_w : dt_w;
        op_b = (dt_w < per_w) ? dt_w : per_w;
      end
      fpc_pkg::ST_DIV2: if (!busy && dt_w < per_w) begin
        req = '{start: 1'b1, is_div: 1'b1};
        op_a = per_w;
        op_b = res_q;
      end
      fpc_pkg::ST_MUL: begin
        req = '{start: 1'b1, is_div: 1'b0};
        if (mode_r == fpc_pkg::MODE_DEGRADE) begin
          op_a = dt_w; op_b = W'(factor_r);
        end else if (mode_r == fpc_pkg::MODE_NRT || mode_r == fpc_pkg::MODE_FORCED) begin
          op_a = cnt_w; op_b = per_w;
        end else begin
          op_a = tmp_r; op_b = per_w;
        end
      end
      fpc_pkg::ST_ECFG: begin
        req = '{start: ecfg_r, is_div: 1'b0};
        op_a = cnt_w; op_b = per_w;
      end
      default: ;
    endcase
  end

  // Final result arithmetic.
  always_comb begin
    target = '0;
    if (mode_r == fpc_pkg::MODE_INT_LIM && dt_w < per_w) target = per_w;
    else if (per_w == '0 || dt_w == '0) target = '0;
    else if (dt_w < per_w) target = res_q;
    else target = (ovf || res_r > TMAX) ? TMAX : res_r;
    ep_sum = epoch_r + res_r;
    sat_t  = ep_sum[W-1] ? '0 : ((ep_sum > TMAX) ? TMAX : ep_sum);
    s1     = {1'b0, old_w} + {1'b0, per_w};
  end

  function automatic logic [W-1:0] satadd(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, TMAX}) ? TMAX : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] maxw(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    logic [W-1:0] d, w, a2;
    if (!rst_n) begin
      st_r       <= fpc_pkg::ST_IDLE;
      mode_r     <= fpc_pkg::MODE_NORMAL;
      period_r   <= fpc_pkg::PERIOD_RESET;
      factor_r   <= fpc_pkg::FACTOR_RESET;
      actual_r   <= '0;
      reported_r <= '0;
      epoch_r    <= '0;
      count_r    <= '0;
      delta_r    <= '0;
      ecfg_r     <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == fpc_pkg::ST_IDLE && wr) begin
        case (widx)
          fpc_pkg::REG_MODE: begin
            mode_r <= fpc_pkg::mode_t'(cfg_pwdata[2:0]);
            ecfg_r <= cfg_pwdata[2:0] == fpc_pkg::MODE_NRT ||
                      cfg_pwdata[2:0] == fpc_pkg::MODE_FORCED;
          end
          fpc_pkg::REG_PERIOD: begin
            period_r <= cfg_pwdata[23:0];
            ecfg_r <= mode_r == fpc_pkg::MODE_NRT || mode_r == fpc_pkg::MODE_FORCED;
          end
          fpc_pkg::REG_FACTOR: factor_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end else if (in_tvalid && in_tready) begin
        now_r <= in_tdata[TIME_BITS-1:0];
        old_r <= (actual_r < in_tdata[TIME_BITS-1:0]) ? actual_r : in_tdata[TIME_BITS-1:0];
        if (mode_r != fpc_pkg::MODE_SLAVE) count_r <= count_r + 1'b1;
      end
      if (st_r == fpc_pkg::ST_ECFGW && !busy) begin
        epoch_r <= rep_w - res_r;
        delta_r <= TIME_BITS'(period_r);
      end
      if (st_r == fpc_pkg::ST_DIV2 && !busy && !(dt_w < per_w))
        tmp_r <= res_q + ((res_r != '0) ? W'(1) : W'(0));
      if (st_r == fpc_pkg::ST_FIN) begin
        if (mode_r == fpc_pkg::MODE_SLAVE) begin
          wait_r <= now_r;
        end else begin
          a2 = now_w;
          case (mode_r)
            fpc_pkg::MODE_NORMAL: begin
              delta_r <= TIME_BITS'(dt_w); reported_r <= now_r;
            end
            fpc_pkg::MODE_NRT: reported_r <= TIME_BITS'(sat_t);
            fpc_pkg::MODE_LIMITED: begin
              w  = (s1 > {1'b0, TMAX}) ? TMAX : s1[W-1:0];
              a2 = maxw(now_w, w);
              delta_r <= TIME_BITS'(a2 - old_w);
              reported_r <= TIME_BITS'(a2);
            end
            fpc_pkg::MODE_INTEGER, fpc_pkg::MODE_INT_LIM: begin
              w  = satadd(old_w, target);
              a2 = maxw(now_w, w);
              delta_r <= TIME_BITS'(target);
              reported_r <= TIME_BITS'(w);
            end
            fpc_pkg::MODE_FORCED: begin
              w  = (s1 > {1'b0, TMAX}) ? TMAX : s1[W-1:0];
              a2 = maxw(now_w, w);
              reported_r <= TIME_BITS'(sat_t);
            end
            default: begin
              d = (ovf || res_r[W-1:8] > TMAX) ? TMAX : {8'd0, res_r[W-1:8]};
              delta_r <= TIME_BITS'(d);
              if (factor_r < 16'd256) begin
                reported_r <= TIME_BITS'(satadd(rep_w, d));
              end else begin
                w  = satadd(old_w, d);
                a2 = maxw(now_w, w);
                reported_r <= TIME_BITS'(a2);
              end
            end
          endcase
          actual_r <= TIME_BITS'(a2);
          wait_r   <= TIME_BITS'(a2);
        end
      end
    end
  end
endmodule

[dv/fpc_checker.sv]
// Checker of the frame pacing clock: tracks register writes, predicts each tick, compares.
`timescale 1ns / 1ps
module fpc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [47:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [175:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);
  localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int DEPTH = 8;

  typedef struct packed {
    logic [47:0] resume_at;
    logic [31:0] number;
    logic [47:0] ftime;
    logic [47:0] delta;
  } frame_report_t;

  // Mirrored registers and clock state.
  fpc_pkg::mode_t  mode_q;
  longint unsigned period_q, factor_q;
  longint unsigned act_t, rep_t, epoch, frames, delta_q;

  // Ring of expected frame reports.
  frame_report_t   exp_buf[DEPTH];
  int              wr_ptr, rd_ptr, exp_cnt;

  assign pending = exp_cnt;

  function automatic longint unsigned sadd(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a || s > TIME_MAX) ? TIME_MAX : s;
  endfunction

  function automatic longint unsigned smul(longint unsigned a, longint unsigned b);
    if (a != 0 && b > TIME_MAX / a) return TIME_MAX;
    return a * b;
  endfunction

  function automatic longint unsigned paced_time();
    longint unsigned v;
    v = epoch + frames * period_q;
    if (v[63]) return 0;
    return v > TIME_MAX ? TIME_MAX : v;
  endfunction

  function automatic void rebase_epoch();
    if (mode_q == fpc_pkg::MODE_NRT || mode_q == fpc_pkg::MODE_FORCED) begin
      epoch   = rep_t - frames * period_q;
      delta_q = period_q;
    end
  endfunction

  function automatic void hold_until(longint unsigned w);
    if (w > act_t) act_t = w;
  endfunction

  // Advance the clock by one tick and return the frame report it causes.
  function automatic frame_report_t advance_clock(longint unsigned now);
    frame_report_t r;
    longint unsigned p, old, dt, tgt, d, q;
    p = period_q;
    if (mode_q == fpc_pkg::MODE_SLAVE) begin
      r.resume_at = now[47:0];
    end else begin
      old    = act_t < now ? act_t : now;
      act_t  = now;
      frames = (frames + 1) & 64'hFFFF_FFFF;
      dt     = now - old;
      case (mode_q)
        fpc_pkg::MODE_NORMAL: begin
          delta_q = dt;
          rep_t   = now;
        end
        fpc_pkg::MODE_NRT: rep_t = paced_time();
        fpc_pkg::MODE_LIMITED: begin
          hold_until(sadd(old, p));
          delta_q = act_t - old;
          rep_t   = act_t;
        end
        fpc_pkg::MODE_INTEGER, fpc_pkg::MODE_INT_LIM: begin
          if (p == 0) tgt = 0;
          else if (dt < p) begin
            if (mode_q == fpc_pkg::MODE_INT_LIM) tgt = p;
            else if (dt == 0) tgt = 0;
            else tgt = p / (p / dt);
          end else begin
            q   = dt / p + ((dt % p) != 0 ? 1 : 0);
            tgt = smul(p, q);
          end
          hold_until(sadd(old, tgt));
          delta_q = tgt;
          rep_t   = sadd(old, tgt);
        end
        fpc_pkg::MODE_FORCED: begin
          hold_until(sadd(old, p));
          rep_t = paced_time();
        end
        default: begin
          // The product fits in 64 bits since dt has 48 and the factor 16.
          d = (dt * factor_q) >> 8;
          if (d > TIME_MAX) d = TIME_MAX;
          delta_q = d;
          if (factor_q < 256) rep_t = sadd(rep_t, d);
          else begin
            hold_until(sadd(old, d));
            rep_t = act_t;
          end
        end
      endcase
      r.resume_at = act_t[47:0];
    end
    r.delta  = delta_q[47:0];
    r.ftime  = rep_t[47:0];
    r.number = frames[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    frame_report_t got, want;
    if (!rst_n) begin
      mode_q   = fpc_pkg::MODE_NORMAL;
      period_q = 64'(fpc_pkg::PERIOD_RESET);
      factor_q = 64'(fpc_pkg::FACTOR_RESET);
      act_t = 0; rep_t = 0; epoch = 0; frames = 0; delta_q = 0;
      wr_ptr = 0; rd_ptr = 0; exp_cnt = 0;
      fail_count = 0;
    end else begin
      // Register writes are only made while the block is idle.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          fpc_pkg::REG_MODE: begin
            mode_q = fpc_pkg::mode_t'(cfg_pwdata[2:0]);
            rebase_epoch();
          end
          fpc_pkg::REG_PERIOD: begin
            period_q = 64'(cfg_pwdata[23:0]);
            rebase_epoch();
          end
          fpc_pkg::REG_FACTOR: factor_q = 64'(cfg_pwdata[15:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (exp_cnt == DEPTH) begin
          $display("%0t: too many requests outstanding", $realtime);
          fail_count++;
        end else begin
          exp_buf[wr_ptr] = advance_clock(64'(in_tdata));
          wr_ptr = (wr_ptr + 1) % DEPTH;
          exp_cnt++;
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (exp_cnt == 0) begin
          $display("%0t: frame report with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = exp_buf[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          exp_cnt--;
          if (got.delta !== want.delta) report_mismatch("frame_delta", got.delta, want.delta);
          if (got.ftime !== want.ftime) report_mismatch("frame_time", got.ftime, want.ftime);
          if (got.number !== want.number)
            report_mismatch("frame_number", got.number, want.number);
          if (got.resume_at !== want.resume_at)
            report_mismatch("resume time", got.resume_at, want.resume_at);
        end
      end
    end
  end
endmodule

[dv/tb.sv]
// Testbench top of the frame pacing clock: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [47:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [175:0] out_tdata;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;
  int           fail_count, pending;
  logic [47:0]  clock_now;
  int           cur_period;

  frame_pacing_clock_top dut (.*);

  fpc_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_pready, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Random receiver stalls: mostly short, a few long, with stall-free stretches.
  int stall_left;
  initial begin
    out_tready = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if ($urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
      end
    end
  end

  // Setup and access cycle of one register write, then time for the epoch update.
  task automatic write_reg(fpc_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    repeat (300) @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // One tick request, then a random gap.
  task automatic send_tick(logic [47:0] t);
    int g;
    in_tdata  <= t;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
        ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Next tick time: mostly moving forward near the period, sometimes back, anywhere or near the top.
  function automatic logic [47:0] next_time();
    int sel;
    logic [47:0] r;
    sel = $urandom_range(0, 99);
    r = 48'({$urandom, $urandom});
    if (sel < 80) return clock_now + $urandom_range(0, 3 * cur_period + 2);
    else if (sel < 86) return clock_now - $urandom_range(0, 1000);
    else if (sel < 93) return r;
    else return TIME_MAX - $urandom_range(0, 5000);
  endfunction

  task automatic run_ticks(int n);
    repeat (n) begin
      clock_now = next_time();
      send_tick(clock_now);
    end
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  initial begin
    int p;
    logic [47:0] directed[$];
    rst_n = 0; in_tvalid = 0; in_tdata = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed ticks at reset settings: extremes and time going backward.
    directed = '{48'd0, TIME_MAX, 48'd5, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'd100};
    foreach (directed[i]) send_tick(directed[i]);
    in_tvalid <= 0;
    settle();

    // Every mode with a short directed burst, zero interval included.
    for (int m = 0; m < 8; m++) begin
      write_reg(fpc_pkg::REG_PERIOD, 1000);
      write_reg(fpc_pkg::REG_MODE, m);
      send_tick(48'd10000); send_tick(48'd10000); send_tick(48'd10300);
      in_tvalid <= 0;
      settle();
    end

    // Register extremes: zero and full period, extreme factors.
    write_reg(fpc_pkg::REG_FACTOR, 0);
    write_reg(fpc_pkg::REG_MODE, fpc_pkg::MODE_DEGRADE);
    send_tick(48'd20000); send_tick(TIME_MAX);
    in_tvalid <= 0;
    settle();
    write_reg(fpc_pkg::REG_FACTOR, 16'hFFFF);
    write_reg(fpc_pkg::REG_PERIOD, 32'hFFFF_FFFF);
    send_tick(48'd1); send_tick(TIME_MAX);
    in_tvalid <= 0;
    settle();
    write_reg(fpc_pkg::REG_PERIOD, 0);
    write_reg(fpc_pkg::REG_MODE, fpc_pkg::MODE_INTEGER);
    send_tick(48'd300); send_tick(48'd900);
    in_tvalid <= 0;
    settle();

    // Random phases over modes, periods and factors.
    clock_now = 0;
    for (int ph = 0; ph < 24; ph++) begin
      case ($urandom_range(0, 9))
        0: p = 1;
        1: p = 24'hFFFFFF;
        2: p = 0;
        default: p = $urandom_range(1, 5000);
      endcase
      cur_period = (p > 5000 || p == 0) ? 5000 : p;
      write_reg(fpc_pkg::REG_FACTOR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(1, 600));
      write_reg(fpc_pkg::REG_PERIOD, p);
      write_reg(fpc_pkg::REG_MODE, (ph < 8) ? ph : $urandom_range(0, 7));
      run_ticks(75);
      // Hold off until the block has answered everything.
      if (ph == 12) while (pending != 0) @(posedge clk);
      settle();
    end

    settle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
